>>> src/pnl_pkg.sv
package pnl_pkg;

  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_READY_WAIT  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACK_WAIT    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_NIB   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_NIB  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NIB_GAP     = 3'd4;

  localparam logic [CfgW-1:0] READY_WAIT_RST = 16'd50000;
  localparam logic [CfgW-1:0] ACK_WAIT_RST   = 16'd500;
  localparam logic [CfgW-1:0] FIRST_NIB_RST  = 16'd500;
  localparam logic [CfgW-1:0] SECOND_NIB_RST = 16'd5000;
  localparam logic [CfgW-1:0] NIB_GAP_RST    = 16'd1000;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_CONNECT = 3'd1;
  localparam logic [2:0] OP_SEND    = 3'd2;
  localparam logic [2:0] OP_RECV    = 3'd3;
  localparam logic [2:0] OP_ABORT   = 3'd4;

  localparam logic [3:0] RC_NONE         = 4'd0;
  localparam logic [3:0] RC_SENT         = 4'd1;
  localparam logic [3:0] RC_SEND_TIMEOUT = 4'd2;
  localparam logic [3:0] RC_RECEIVED     = 4'd3;
  localparam logic [3:0] RC_NOTHING      = 4'd4;
  localparam logic [3:0] RC_LOW_TIMEOUT  = 4'd5;
  localparam logic [3:0] RC_REL_TIMEOUT  = 4'd6;
  localparam logic [3:0] RC_CONNECTED    = 4'd7;
  localparam logic [3:0] RC_ABORTED      = 4'd8;

  localparam logic [7:0] ROLE_MASK     = 8'hF8;
  localparam logic [7:0] ROLE_IDLE_PAT = 8'hF8;
  localparam logic [7:0] ROLE_ANSWER   = 8'h50;
  localparam logic [4:0] CONN_HELLO    = 5'h0F;
  localparam logic [4:0] CONN_REPLY    = 5'h1A;
  localparam logic [4:0] STROBE        = 5'h10;

  typedef struct packed {
    logic [CfgW-1:0] ready_wait_limit;
    logic [CfgW-1:0] ack_wait_limit;
    logic [CfgW-1:0] first_nibble_limit;
    logic [CfgW-1:0] second_nibble_limit;
    logic [CfgW-1:0] nibble_gap_ticks;
  } pnl_cfg_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic [7:0] status_byte;
  } pnl_in_t;

  typedef struct packed {
    logic [4:0] data_drive;
    logic       busy_res;
    logic       done_res;
    logic [3:0] result_code;
    logic [7:0] rx_byte;
  } pnl_res_t;

endpackage

>>> src/pnl_if.sv
interface pnl_in_if;
  import pnl_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] tx_byte;
  logic [7:0] status_byte;
  modport source (output valid, opcode, tx_byte, status_byte, input ready);
  modport sink (input valid, opcode, tx_byte, status_byte, output ready);
endinterface

interface pnl_out_if;
  import pnl_pkg::*;
  logic       valid;
  logic       ready;
  logic [4:0] data_drive;
  logic       busy_res;
  logic       done_res;
  logic [3:0] result_code;
  logic [7:0] rx_byte;
  modport source (output valid, data_drive, busy_res, done_res, result_code, rx_byte,
                  input ready);
  modport sink (input valid, data_drive, busy_res, done_res, result_code, rx_byte,
                output ready);
endinterface

>>> src/pnl_cfg_regs.sv
module pnl_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [pnl_pkg::CfgIdxW-1:0]    idx_i,
  input  logic [pnl_pkg::CfgW-1:0]       data_i,
  output pnl_pkg::pnl_cfg_t              cfg_o
);
  import pnl_pkg::*;

  pnl_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        CFG_READY_WAIT: cfg_d.ready_wait_limit    = data_i;
        CFG_ACK_WAIT:   cfg_d.ack_wait_limit      = data_i;
        CFG_FIRST_NIB:  cfg_d.first_nibble_limit  = data_i;
        CFG_SECOND_NIB: cfg_d.second_nibble_limit = data_i;
        CFG_NIB_GAP:    cfg_d.nibble_gap_ticks    = data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ready_wait_limit    <= READY_WAIT_RST;
      cfg_q.ack_wait_limit      <= ACK_WAIT_RST;
      cfg_q.first_nibble_limit  <= FIRST_NIB_RST;
      cfg_q.second_nibble_limit <= SECOND_NIB_RST;
      cfg_q.nibble_gap_ticks    <= NIB_GAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/pnl_step.sv
module pnl_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  pnl_pkg::pnl_in_t   in_i,
  input  pnl_pkg::pnl_cfg_t  cfg_i,
  output pnl_pkg::pnl_res_t  res_o
);
  import pnl_pkg::*;

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_CONN_INIT  = 4'd1;
  localparam logic [3:0] PH_CONN_RSP1  = 4'd2;
  localparam logic [3:0] PH_CONN_RSP2  = 4'd3;
  localparam logic [3:0] PH_TX_READY   = 4'd4;
  localparam logic [3:0] PH_TX_RELEASE = 4'd5;
  localparam logic [3:0] PH_RX_WAIT    = 4'd6;
  localparam logic [3:0] PH_RX_RELEASE = 4'd7;
  localparam logic [3:0] PH_RX_GAP     = 4'd8;

  logic [3:0]  phase_q, phase_d;
  logic        nib_q, nib_d;
  logic [7:0]  asm_q, asm_d;
  logic [3:0]  ptx_q, ptx_d;
  logic [15:0] poll_q, poll_d;
  logic [4:0]  drv_q, drv_d;

  logic [15:0] poll_inc;
  logic        partner;
  logic [7:0]  role_bits;
  logic        done;
  logic [3:0]  code;

  assign partner   = in_i.status_byte[7];
  assign role_bits = in_i.status_byte & ROLE_MASK;
  assign poll_inc  = (poll_q == 16'hFFFF) ? poll_q : poll_q + 16'd1;

  always_comb begin
    phase_d = phase_q;
    nib_d   = nib_q;
    asm_d   = asm_q;
    ptx_d   = ptx_q;
    poll_d  = poll_q;
    drv_d   = drv_q;
    done    = 1'b0;
    code    = RC_NONE;
    if (phase_q == PH_IDLE) begin
      case (in_i.opcode)
        OP_CONNECT: begin
          drv_d   = CONN_HELLO;
          phase_d = (role_bits == ROLE_IDLE_PAT) ? PH_CONN_INIT : PH_CONN_RSP1;
        end
        OP_SEND: begin
          ptx_d   = in_i.tx_byte[3:0];
          nib_d   = 1'b0;
          poll_d  = '0;
          drv_d   = {1'b0, in_i.tx_byte[7:4]};
          phase_d = PH_TX_READY;
        end
        OP_RECV: begin
          asm_d   = '0;
          nib_d   = 1'b0;
          poll_d  = '0;
          phase_d = PH_RX_WAIT;
        end
        default: ;
      endcase
    end else if (in_i.opcode == OP_ABORT) begin
      phase_d = PH_IDLE;
      drv_d   = '0;
      done    = 1'b1;
      code    = RC_ABORTED;
    end else begin
      case (phase_q)
        PH_CONN_INIT: begin
          if (role_bits == ROLE_ANSWER) begin
            drv_d   = CONN_REPLY;
            phase_d = PH_IDLE;
            done    = 1'b1;
            code    = RC_CONNECTED;
          end
        end
        PH_CONN_RSP1: begin
          if (role_bits == ROLE_IDLE_PAT) begin
            drv_d   = CONN_REPLY;
            phase_d = PH_CONN_RSP2;
          end
        end
        PH_CONN_RSP2: begin
          if (role_bits == ROLE_ANSWER) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
            code    = RC_CONNECTED;
          end
        end
        PH_TX_READY: begin
          if (partner) begin
            drv_d   = STROBE;
            poll_d  = '0;
            phase_d = PH_TX_RELEASE;
          end else begin
            poll_d = poll_inc;
            if (poll_inc >= cfg_i.ready_wait_limit) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
              code    = RC_SEND_TIMEOUT;
            end
          end
        end
        PH_TX_RELEASE: begin
          if (!partner) begin
            if (!nib_q) begin
              nib_d   = 1'b1;
              poll_d  = '0;
              drv_d   = {1'b0, ptx_q};
              phase_d = PH_TX_READY;
            end else begin
              phase_d = PH_IDLE;
              done    = 1'b1;
              code    = RC_SENT;
            end
          end else begin
            poll_d = poll_inc;
            if (poll_inc >= cfg_i.ack_wait_limit) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
              code    = RC_SEND_TIMEOUT;
            end
          end
        end
        PH_RX_WAIT: begin
          if (partner) begin
            if (!nib_q) begin
              asm_d = asm_q | {in_i.status_byte[6:3], 4'b0000};
            end else begin
              asm_d = asm_q | {4'b0000, in_i.status_byte[6:3]};
            end
            drv_d   = '0;
            poll_d  = '0;
            phase_d = PH_RX_RELEASE;
          end else begin
            poll_d = poll_inc;
            if (!nib_q) begin
              if (poll_inc >= cfg_i.first_nibble_limit) begin
                phase_d = PH_IDLE;
                done    = 1'b1;
                code    = RC_NOTHING;
              end
            end else if (poll_inc >= cfg_i.second_nibble_limit) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
              code    = RC_LOW_TIMEOUT;
            end
          end
        end
        PH_RX_RELEASE: begin
          if (!partner) begin
            drv_d  = STROBE;
            poll_d = '0;
            if (nib_q) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
              code    = RC_RECEIVED;
            end else begin
              nib_d   = 1'b1;
              phase_d = (cfg_i.nibble_gap_ticks != '0) ? PH_RX_GAP : PH_RX_WAIT;
            end
          end else begin
            poll_d = poll_inc;
            if (poll_inc >= cfg_i.ack_wait_limit) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
              code    = RC_REL_TIMEOUT;
            end
          end
        end
        PH_RX_GAP: begin
          poll_d = poll_inc;
          if (poll_inc >= cfg_i.nibble_gap_ticks) begin
            poll_d  = '0;
            phase_d = PH_RX_WAIT;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      nib_q   <= 1'b0;
      asm_q   <= '0;
      ptx_q   <= '0;
      poll_q  <= '0;
      drv_q   <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      nib_q   <= nib_d;
      asm_q   <= asm_d;
      ptx_q   <= ptx_d;
      poll_q  <= poll_d;
      drv_q   <= drv_d;
    end
  end

  assign res_o.data_drive  = drv_d;
  assign res_o.busy_res    = (phase_d != PH_IDLE);
  assign res_o.done_res    = done;
  assign res_o.result_code = code;
  assign res_o.rx_byte     = (done && code >= RC_RECEIVED && code <= RC_REL_TIMEOUT) ?
                             asm_d : 8'h00;

endmodule

>>> src/parallel_port_nibble_link_core.sv
// Channel  Dir  Beat contents
// item_i   in   opcode, tx_byte, status_byte (one poll tick)
// res_o    out  data_drive, busy_res, done_res, result_code, rx_byte
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One beat per clock while res_o is ready; a stalled res_o holds back the input stage.
// A beat passes the input register, the step logic and then the result register.
// item_i stays ready while the input stage is empty, even if a result waits on res_o.
// Reset puts the controller idle, drive at zero, limits at their defaults.
module parallel_port_nibble_link_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pnl_in_if.sink                      item_i,
  pnl_out_if.source                   res_o,
  input  logic                        cfg_we_i,
  input  logic [pnl_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pnl_pkg::CfgW-1:0]    cfg_data_i
);
  import pnl_pkg::*;

  pnl_cfg_t cfg;
  pnl_in_t  in_q;
  logic     in_vld_q;
  pnl_res_t step_res;
  pnl_res_t out_q;
  logic     out_vld_q;
  logic     advance;

  assign advance      = in_vld_q && (!out_vld_q || res_o.ready);
  assign item_i.ready = !in_vld_q || advance;

  pnl_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  pnl_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .in_i   (in_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (item_i.ready) begin
      in_vld_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      in_q.opcode      <= item_i.opcode;
      in_q.tx_byte     <= item_i.tx_byte;
      in_q.status_byte <= item_i.status_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.data_drive  = out_q.data_drive;
  assign res_o.busy_res    = out_q.busy_res;
  assign res_o.done_res    = out_q.done_res;
  assign res_o.result_code = out_q.result_code;
  assign res_o.rx_byte     = out_q.rx_byte;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.done_res |-> !res_o.busy_res)
    else $error("done beat still busy");

  a_done_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.done_res == (res_o.result_code != RC_NONE)))
    else $error("done flag and result code disagree");

  a_rx_only_on_rx_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.rx_byte != 8'h00 |->
      res_o.done_res && (res_o.result_code == RC_RECEIVED ||
      res_o.result_code == RC_NOTHING || res_o.result_code == RC_LOW_TIMEOUT ||
      res_o.result_code == RC_REL_TIMEOUT))
    else $error("rx_byte set outside a receive completion");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("stepped item lost its result");

endmodule
